@@ design/pidc_pkg.sv @@
// Shared widths and constants for the PID position and velocity controller.
package pidc_pkg;

  // Bit-serial multiplier: wide magnitude times a short magnitude.
  localparam int PIDC_MUL_A_W = 48;
  localparam int PIDC_MUL_B_W = 16;

  // Bit-serial divider: quotient width and divisor width.
  localparam int PIDC_DIV_N_W = 42;
  localparam int PIDC_DIV_D_W = 10;

  localparam logic [PIDC_DIV_D_W-1:0] PIDC_MS_PER_SEC = 10'd1000;

endpackage

@@ design/pid_position_velocity_controller.sv @@
// PID controller top level: register port, tick sequencer and shared serial arithmetic.
// Ticks are taken one at a time; an enabled tick that gives a drive may also wait for the
// result register. Enabled ticks run on the bit-serial multiplier (five products at most)
// and the bit-serial divider (two quotients).
// Synchronous active-low reset puts the gains at 0, substep_ms and substeps_per_output at 10,
// clears mode and enable, and zeroes the integral, derivative, last error and tick count.
module pid_position_velocity_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_position,
  input  logic [31:0] in_velocity,
  input  logic [31:0] in_setpoint,
  input  logic        in_clear,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_drive,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pidc_pkg::*;

  localparam logic [2:0] REG_KP      = 3'd0;
  localparam logic [2:0] REG_KI      = 3'd1;
  localparam logic [2:0] REG_KD      = 3'd2;
  localparam logic [2:0] REG_SUBSTEP = 3'd3;
  localparam logic [2:0] REG_PERIOD  = 3'd4;
  localparam logic [2:0] REG_MODE    = 3'd5;
  localparam logic [2:0] REG_ENABLE  = 3'd6;

  localparam int P_W = PIDC_MUL_A_W + PIDC_MUL_B_W;

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b0000000001,
    ST_LOAD      = 10'b0000000010,
    ST_ISTEP_MUL = 10'b0000000100,
    ST_ISTEP_DIV = 10'b0000001000,
    ST_DERIV_MUL = 10'b0000010000,
    ST_DERIV_DIV = 10'b0000100000,
    ST_KP_MUL    = 10'b0001000000,
    ST_KI_MUL    = 10'b0010000000,
    ST_KD_MUL    = 10'b0100000000,
    ST_OUT       = 10'b1000000000
  } state_t;

  // Configuration registers.
  logic [15:0] kp_r, ki_r, kd_r;
  logic [9:0]  substep_r;
  logic [7:0]  period_r;
  logic        mode_r;
  logic        enable_r;
  logic        cfg_wr;

  // Controller state and working registers.
  state_t      state_r, state_nxt;
  logic [31:0] err_r, err_nxt;
  logic [32:0] diff_r, diff_nxt;
  logic [47:0] integ_r, integ_nxt;
  logic [31:0] deriv_r, deriv_nxt;
  logic [31:0] prev_r, prev_nxt;
  logic [7:0]  tick_r, tick_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_drive_r, out_drive_nxt;

  // Arithmetic unit hookup.
  logic                    mul_start, mul_done;
  logic [PIDC_MUL_A_W-1:0] mul_a;
  logic [PIDC_MUL_B_W-1:0] mul_b;
  logic [P_W-1:0]          mul_p;
  logic                    div_start, div_done;
  logic [PIDC_DIV_N_W-1:0] div_n, div_q;
  logic [PIDC_DIV_D_W-1:0] div_d;

  // Helpers.
  logic        accept;
  logic [31:0] meas;
  logic [32:0] meas_diff;
  logic [31:0] err_sat;
  logic [9:0]  dt;
  logic [7:0]  period;
  logic [7:0]  tick_inc;
  logic [31:0] err_abs;
  logic [32:0] diff_abs;
  logic [47:0] integ_abs;
  logic [31:0] deriv_abs;
  logic [15:0] kp_abs, ki_abs, kd_abs;
  logic [48:0] integ_sum;
  logic [47:0] integ_sat;
  logic [31:0] deriv_sat;
  logic [63:0] acc_step;
  logic        acc_neg;
  logic [31:0] drive_sat;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r      <= '0;
      ki_r      <= '0;
      kd_r      <= '0;
      substep_r <= 10'd10;
      period_r  <= 8'd10;
      mode_r    <= 1'b0;
      enable_r  <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_KP:      kp_r      <= pwdata[15:0];
        REG_KI:      ki_r      <= pwdata[15:0];
        REG_KD:      kd_r      <= pwdata[15:0];
        REG_SUBSTEP: substep_r <= pwdata[9:0];
        REG_PERIOD:  period_r  <= pwdata[7:0];
        REG_MODE:    mode_r    <= pwdata[0];
        REG_ENABLE:  enable_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_KP:      prdata = {16'd0, kp_r};
      REG_KI:      prdata = {16'd0, ki_r};
      REG_KD:      prdata = {16'd0, kd_r};
      REG_SUBSTEP: prdata = {22'd0, substep_r};
      REG_PERIOD:  prdata = {24'd0, period_r};
      REG_MODE:    prdata = {31'd0, mode_r};
      REG_ENABLE:  prdata = {31'd0, enable_r};
      default:     prdata = '0;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid & in_ready;

  // Error is taken at the input edge and clamped to the 32-bit range.
  assign meas      = mode_r ? in_velocity : in_position;
  assign meas_diff = {meas[31], meas} - {in_setpoint[31], in_setpoint};
  assign err_sat   = (meas_diff[32] != meas_diff[31]) ?
                     (meas_diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : meas_diff[31:0];

  assign dt       = (substep_r == '0) ? 10'd1 : substep_r;
  assign period   = (period_r == '0) ? 8'd1 : period_r;
  assign tick_inc = tick_r + 8'd1;

  assign err_abs   = err_r[31]   ? (~err_r + 32'd1)   : err_r;
  assign diff_abs  = diff_r[32]  ? (~diff_r + 33'd1)  : diff_r;
  assign integ_abs = integ_r[47] ? (~integ_r + 48'd1) : integ_r;
  assign deriv_abs = deriv_r[31] ? (~deriv_r + 32'd1) : deriv_r;
  assign kp_abs    = kp_r[15] ? (~kp_r + 16'd1) : kp_r;
  assign ki_abs    = ki_r[15] ? (~ki_r + 16'd1) : ki_r;
  assign kd_abs    = kd_r[15] ? (~kd_r + 16'd1) : kd_r;

  // The integral step magnitude stays below 2^32, so 32 quotient bits carry it.
  assign integ_sum = err_r[31] ? ({integ_r[47], integ_r} - {17'd0, div_q[31:0]})
                               : ({integ_r[47], integ_r} + {17'd0, div_q[31:0]});
  assign integ_sat = (integ_sum[48] != integ_sum[47]) ?
                     (integ_sum[48] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF) :
                     integ_sum[47:0];

  always_comb begin
    if (diff_r[32]) begin
      deriv_sat = (div_q > 42'h0_8000_0000) ? 32'h8000_0000 : (~div_q[31:0] + 32'd1);
    end else begin
      deriv_sat = (div_q > 42'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : div_q[31:0];
    end
  end

  // Signed product folded into the accumulator as one add or subtract.
  always_comb begin
    case (state_r)
      ST_KP_MUL: acc_neg = kp_r[15] ^ err_r[31];
      ST_KI_MUL: acc_neg = ki_r[15] ^ integ_r[47];
      ST_KD_MUL: acc_neg = kd_r[15] ^ deriv_r[31];
      default:   acc_neg = 1'b0;
    endcase
  end
  assign acc_step = acc_neg ? (acc_r - mul_p) : (acc_r + mul_p);

  // Drive is the accumulator shifted right by eight, floor rounded, then clamped.
  assign drive_sat = (acc_r[63:39] != {25{acc_r[63]}}) ?
                     (acc_r[63] ? 32'h8000_0000 : 32'h7FFF_FFFF) : acc_r[39:8];

  always_comb begin
    state_nxt     = state_r;
    err_nxt       = err_r;
    diff_nxt      = diff_r;
    integ_nxt     = integ_r;
    deriv_nxt     = deriv_r;
    prev_nxt      = prev_r;
    tick_nxt      = tick_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_drive_nxt = out_drive_r;
    mul_start     = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    div_start     = 1'b0;
    div_n         = mul_p[PIDC_DIV_N_W-1:0];
    div_d         = PIDC_MS_PER_SEC;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_clear) begin
            prev_nxt = '0;
            tick_nxt = '0;
          end
          if (enable_r) begin
            err_nxt   = err_sat;
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        diff_nxt  = {err_r[31], err_r} - {prev_r[31], prev_r};
        mul_start = 1'b1;
        mul_a     = {16'd0, err_abs};
        mul_b     = {6'd0, dt};
        state_nxt = ST_ISTEP_MUL;
      end
      ST_ISTEP_MUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_d     = PIDC_MS_PER_SEC;
          state_nxt = ST_ISTEP_DIV;
        end
      end
      ST_ISTEP_DIV: begin
        if (div_done) begin
          integ_nxt = integ_sat;
          mul_start = 1'b1;
          mul_a     = {15'd0, diff_abs};
          mul_b     = {6'd0, PIDC_MS_PER_SEC};
          state_nxt = ST_DERIV_MUL;
        end
      end
      ST_DERIV_MUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_d     = dt;
          state_nxt = ST_DERIV_DIV;
        end
      end
      ST_DERIV_DIV: begin
        if (div_done) begin
          deriv_nxt = deriv_sat;
          prev_nxt  = err_r;
          if (tick_inc < period) begin
            tick_nxt  = tick_inc;
            state_nxt = ST_IDLE;
          end else begin
            tick_nxt  = '0;
            acc_nxt   = '0;
            mul_start = 1'b1;
            mul_a     = {16'd0, err_abs};
            mul_b     = kp_abs;
            state_nxt = ST_KP_MUL;
          end
        end
      end
      ST_KP_MUL: begin
        if (mul_done) begin
          acc_nxt   = acc_step;
          mul_start = 1'b1;
          mul_a     = integ_abs;
          mul_b     = ki_abs;
          state_nxt = ST_KI_MUL;
        end
      end
      ST_KI_MUL: begin
        if (mul_done) begin
          acc_nxt   = acc_step;
          mul_start = 1'b1;
          mul_a     = {16'd0, deriv_abs};
          mul_b     = kd_abs;
          state_nxt = ST_KD_MUL;
        end
      end
      ST_KD_MUL: begin
        if (mul_done) begin
          acc_nxt   = acc_step;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // Wait here until the output register is free or is emptied this cycle.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_drive_nxt = drive_sat;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      integ_r     <= '0;
      deriv_r     <= '0;
      prev_r      <= '0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      integ_r     <= integ_nxt;
      deriv_r     <= deriv_nxt;
      prev_r      <= prev_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
    end
    err_r       <= err_nxt;
    diff_r      <= diff_nxt;
    acc_r       <= acc_nxt;
    out_drive_r <= out_drive_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

  pidc_mul #(
    .A_W(PIDC_MUL_A_W),
    .B_W(PIDC_MUL_B_W)
  ) u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (mul_p)
  );

  pidc_div #(
    .N_W(PIDC_DIV_N_W),
    .D_W(PIDC_DIV_D_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_n),
    .divisor (div_d),
    .done    (div_done),
    .quot    (div_q)
  );

endmodule

@@ design/pidc_mul.sv @@
// Shift-and-add multiplier of two unsigned magnitudes, one multiplier bit per cycle.
module pidc_mul #(
  parameter int A_W = pidc_pkg::PIDC_MUL_A_W,
  parameter int B_W = pidc_pkg::PIDC_MUL_B_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               done,
  output logic [A_W+B_W-1:0] prod
);
  import pidc_pkg::*;

  localparam int CNT_W = $clog2(B_W + 1);

  logic [A_W-1:0]   a_r, a_nxt;
  logic [A_W-1:0]   hi_r, hi_nxt;
  logic [B_W-1:0]   lo_r, lo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [A_W:0]     sum;

  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);

  always_comb begin
    a_nxt    = a_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt   = a;
      hi_nxt  = '0;
      lo_nxt  = b;
      cnt_nxt = CNT_W'(B_W);
    end else if (cnt_r != '0) begin
      // The low half holds the unused multiplier bits and collects product bits.
      hi_nxt   = sum[A_W:1];
      lo_nxt   = {sum[0], lo_r[B_W-1:1]};
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    a_r  <= a_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign done = done_r;
  assign prod = {hi_r, lo_r};

endmodule

@@ design/pidc_div.sv @@
// Restoring divider of unsigned magnitudes, one quotient bit per cycle.
module pidc_div #(
  parameter int N_W = pidc_pkg::PIDC_DIV_N_W,
  parameter int D_W = pidc_pkg::PIDC_DIV_D_W
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           done,
  output logic [N_W-1:0] quot
);
  import pidc_pkg::*;

  localparam int CNT_W = $clog2(N_W + 1);

  logic [D_W-1:0]   rem_r, rem_nxt;
  logic [N_W-1:0]   q_r, q_nxt;
  logic [D_W-1:0]   d_r, d_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [D_W:0]     r_sh;
  logic [D_W:0]     r_sub;
  logic             ge;

  assign r_sh  = {rem_r, q_r[N_W-1]};
  assign r_sub = r_sh - {1'b0, d_r};
  assign ge    = (r_sh >= {1'b0, d_r});

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      q_nxt   = dividend;
      d_nxt   = divisor;
      cnt_nxt = CNT_W'(N_W);
    end else if (cnt_r != '0) begin
      // Dividend bits leave at the top while quotient bits enter at the bottom.
      rem_nxt  = ge ? r_sub[D_W-1:0] : r_sh[D_W-1:0];
      q_nxt    = {q_r[N_W-2:0], ge};
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

@@ test/tb_pid_position_velocity_controller.sv @@
// Self-checking testbench for the PID position and velocity controller.
module tb_pid_position_velocity_controller;
  import pidc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2500000;
  localparam int unsigned SETTLE_CYCLES = 250;
  localparam int unsigned SQUEEZE_CYCLES = 800;
  localparam int unsigned RANDOM_TICKS = 1500;
  localparam longint MS_PER_SEC = longint'(PIDC_MS_PER_SEC);
  localparam longint I32_MAX = 64'sh7FFF_FFFF;
  localparam longint I32_MIN = -I32_MAX - 1;
  localparam longint I48_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint I48_MIN = -I48_MAX - 1;

  typedef enum logic [2:0] {
    REG_KP, REG_KI, REG_KD, REG_SUBSTEP_MS, REG_PERIOD, REG_MODE, REG_ENABLE, REG_SPARE
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] kp;
    logic [15:0] ki;
    logic [15:0] kd;
    logic [9:0]  ms;
    logic [7:0]  per;
    logic        mode;
    logic        en;
  } ctrl_cfg_t;

  typedef struct packed {
    logic [2:0]  ph;
    logic [31:0] pos;
    logic [31:0] vel;
    logic [31:0] sp;
    logic        clr;
    logic        typed;
    logic        fires;
    logic [31:0] drv;
  } tick_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_position = '0;
  logic [31:0] in_velocity = '0;
  logic [31:0] in_setpoint = '0;
  logic        in_clear = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_drive;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pid_position_velocity_controller uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_position(in_position), .in_velocity(in_velocity),
    .in_setpoint(in_setpoint), .in_clear(in_clear),
    .out_valid(out_valid), .out_ready(out_ready), .out_drive(out_drive),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the block: register copy and controller state.
  ctrl_cfg_t   cur = '{16'h0, 16'h0, 16'h0, 10'd10, 8'd10, 1'b0, 1'b0};
  longint      integ = 0;
  longint      deriv = 0;
  longint      last_err = 0;
  logic [7:0]  tick_cnt = '0;

  logic [31:0] drive_q[$];
  logic [31:0] want_drive;
  int unsigned fails = 0;
  int unsigned cycle_no = 0;
  bit          calm = 1'b0;
  bit          tx_eager = 1'b0;
  bit          squeeze_req = 1'b0;

  ctrl_cfg_t phases [0:6] = '{
    '{16'h0000, 16'h0000, 16'h0000, 10'd10,   8'd10, 1'b0, 1'b0},
    '{16'h0100, 16'h0000, 16'h0000, 10'd10,   8'd1,  1'b0, 1'b1},
    '{16'h7FFF, 16'h7FFF, 16'h7FFF, 10'd1000, 8'd1,  1'b1, 1'b1},
    '{16'h8000, 16'h8000, 16'h8000, 10'd0,    8'd0,  1'b0, 1'b1},
    '{16'h0180, 16'h0040, 16'hFF00, 10'd1023, 8'd3,  1'b1, 1'b1},
    '{16'h0180, 16'h0040, 16'hFF00, 10'd1023, 8'd3,  1'b1, 1'b0},
    '{16'h0200, 16'hFFC0, 16'h0010, 10'd7,    8'd2,  1'b0, 1'b1}
  };

  // Rows with typed set carry their own expectation; the others go through the shadow model.
  tick_row_t plan [0:23] = '{
    '{3'd0, 32'h7FFFFFFF, 32'h80000000, 32'h00000000, 1'b0, 1'b1, 1'b0, 32'h0},
    '{3'd0, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, 1'b0, 32'h0},
    '{3'd1, 32'h7FFFFFFF, 32'h00000000, 32'h80000000, 1'b0, 1'b1, 1'b1, 32'h7FFFFFFF},
    '{3'd1, 32'h80000000, 32'hFFFFFFFF, 32'h7FFFFFFF, 1'b0, 1'b1, 1'b1, 32'h80000000},
    '{3'd1, 32'h00012345, 32'h00000000, 32'h00012345, 1'b0, 1'b1, 1'b1, 32'h00000000},
    '{3'd1, 32'h00030000, 32'hFFFFFFFF, 32'h00010000, 1'b0, 1'b1, 1'b1, 32'h00020000},
    '{3'd2, 32'h12345678, 32'h7FFFFFFF, 32'h80000000, 1'b0, 1'b0, 1'b0, 32'h0},
    '{3'd2, 32'h00000000, 32'h80000000, 32'h7FFFFFFF, 1'b0, 1'b0, 1'b0, 32'h0},
    '{3'd2, 32'hFFFFFFFF, 32'h00000000, 32'h00000000, 1'b0, 1'b0, 1'b0, 32'h0},
    '{3'd2, 32'h7FFFFFFF, 32'h00000100, 32'h00000000, 1'b1, 1'b0, 1'b0, 32'h0},
    '{3'd3, 32'h7FFFFFFF, 32'hAAAAAAAA, 32'hFFFFFFFF, 1'b0, 1'b0, 1'b0, 32'h0},
    '{3'd3, 32'hFFFF0000, 32'h55555555, 32'h00010000, 1'b0, 1'b0, 1'b0, 32'h0},
    '{3'd3, 32'h00000001, 32'h00000000, 32'h00000000, 1'b1, 1'b0, 1'b0, 32'h0},
    '{3'd3, 32'h80000000, 32'h00000000, 32'h00000001, 1'b0, 1'b0, 1'b0, 32'h0},
    '{3'd4, 32'h00000000, 32'h00018000, 32'h00010000, 1'b0, 1'b0, 1'b0, 32'h0},
    '{3'd4, 32'h00000000, 32'hFFFF8000, 32'h00000000, 1'b0, 1'b0, 1'b0, 32'h0},
    '{3'd4, 32'h00000000, 32'h00004000, 32'h00008000, 1'b1, 1'b0, 1'b0, 32'h0},
    '{3'd4, 32'h00000000, 32'h00020000, 32'h00020000, 1'b0, 1'b0, 1'b0, 32'h0},
    '{3'd4, 32'h00000000, 32'h7FFF0000, 32'hFFFF0000, 1'b0, 1'b0, 1'b0, 32'h0},
    '{3'd4, 32'h00000000, 32'h00000010, 32'h00000020, 1'b0, 1'b0, 1'b0, 32'h0},
    '{3'd5, 32'h00050000, 32'h00000000, 32'h00010000, 1'b1, 1'b1, 1'b0, 32'h0},
    '{3'd5, 32'h00050000, 32'h00000000, 32'h00010000, 1'b0, 1'b1, 1'b0, 32'h0},
    '{3'd6, 32'h00050000, 32'h00000000, 32'h00010000, 1'b0, 1'b0, 1'b0, 32'h0},
    '{3'd6, 32'hFFF80000, 32'h00000000, 32'h00010000, 1'b0, 1'b0, 1'b0, 32'h0}
  };

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advances the shadow controller by one tick and tells whether a drive comes out.
  task automatic step_controller(input logic [31:0] pos, input logic [31:0] vel,
                                 input logic [31:0] sp, input logic clr,
                                 output bit fired, output logic [31:0] drv);
    longint meas, err, dt, acc;
    int unsigned period;
    fired = 1'b0;
    drv = '0;
    if (clr) begin
      last_err = 0;
      tick_cnt = '0;
    end
    if (!cur.en) return;
    meas = cur.mode ? longint'($signed(vel)) : longint'($signed(pos));
    err = clamp(meas - longint'($signed(sp)), I32_MIN, I32_MAX);
    dt = (cur.ms == '0) ? 1 : longint'(cur.ms);
    integ = clamp(integ + (err * dt) / MS_PER_SEC, I48_MIN, I48_MAX);
    deriv = clamp(((err - last_err) * MS_PER_SEC) / dt, I32_MIN, I32_MAX);
    last_err = err;
    period = (cur.per == '0) ? 1 : cur.per;
    tick_cnt = tick_cnt + 8'd1;
    if (tick_cnt < period) return;
    tick_cnt = '0;
    acc = longint'($signed(cur.kp)) * err + longint'($signed(cur.ki)) * integ
        + longint'($signed(cur.kd)) * deriv;
    // Arithmetic shift gives the floor of the Q.8 sum divided by 256.
    drv = 32'(clamp(acc >>> 8, I32_MIN, I32_MAX));
    fired = 1'b1;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    fails++;
    $display("mismatch on %s: got %h, expected %h, cycle %0d", what, got, exp_val, cycle_no);
  endtask

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] edge_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h00000000;
      3: return 32'hFFFFFFFF;
      4: return 32'h00000001;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'(edge_word() >> 16);
    if (r < 65) return 16'($urandom_range(0, 16'h0800)) - 16'h0400;
    return 16'($urandom());
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // Lets the block go idle, then loads a new register set; upper bits carry noise.
  task automatic switch_phase(ctrl_cfg_t c);
    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_KP, {16'($urandom()), c.kp});
    write_reg(REG_KI, {16'($urandom()), c.ki});
    write_reg(REG_KD, {16'($urandom()), c.kd});
    write_reg(REG_SUBSTEP_MS, {22'($urandom()), c.ms});
    write_reg(REG_PERIOD, {24'($urandom()), c.per});
    write_reg(REG_MODE, {31'($urandom()), c.mode});
    write_reg(REG_ENABLE, {31'($urandom()), c.en});
    write_reg(REG_SPARE, $urandom());
    cur = c;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic offer_tick(input logic [31:0] p, input logic [31:0] v,
                            input logic [31:0] s, input logic k);
    in_valid <= 1'b1;
    in_position <= p;
    in_velocity <= v;
    in_setpoint <= s;
    in_clear <= k;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_sender();
    int unsigned g;
    g = (tx_eager || calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        out_ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
      end else if (calm || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (drive_q.size() == 0) begin
        report_mismatch("drive with no tick pending", out_drive, 'x);
      end else begin
        want_drive = drive_q.pop_front();
        if (out_drive !== want_drive) report_mismatch("drive", out_drive, want_drive);
      end
    end
  end

  always @(posedge clk) begin
    cycle_no++;
    if (cycle_no > CYCLE_LIMIT) begin
      $display("[pid_position_velocity_controller] ERROR");
      $finish;
    end
  end

  initial begin
    ctrl_cfg_t c;
    logic [31:0] p, v, s, d;
    logic k;
    bit fired;
    int unsigned len, n_ticks, ph_no, style;
    int cur_ph;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cur_ph = 0;
    for (int i = 0; i < 24; i++) begin
      if (int'(plan[i].ph) != cur_ph) begin
        cur_ph = plan[i].ph;
        switch_phase(phases[cur_ph]);
      end
      offer_tick(plan[i].pos, plan[i].vel, plan[i].sp, plan[i].clr);
      step_controller(plan[i].pos, plan[i].vel, plan[i].sp, plan[i].clr, fired, d);
      if (plan[i].typed) begin
        if (plan[i].fires) drive_q.push_back(plan[i].drv);
      end else if (fired) begin
        drive_q.push_back(d);
      end
      pause_sender();
    end

    n_ticks = 0;
    ph_no = 0;
    while (n_ticks < RANDOM_TICKS) begin
      c.kp = pick_gain();
      c.ki = pick_gain();
      c.kd = pick_gain();
      case ($urandom_range(0, 9))
        0: c.ms = 10'd0;
        1: c.ms = 10'd1000;
        2: c.ms = 10'd1023;
        3: c.ms = 10'd1;
        default: c.ms = 10'($urandom_range(1, 1023));
      endcase
      style = $urandom_range(0, 99);
      c.per = (style < 5) ? 8'd0 : (style < 10) ? 8'd255 : (style < 25) ? 8'd1
            : 8'($urandom_range(2, 8));
      c.mode = 1'($urandom_range(0, 1));
      c.en = ($urandom_range(0, 99) < 85);
      // The third random phase is the one where the result side stops for a long while.
      if (ph_no == 2) begin
        c.en = 1'b1;
        c.per = 8'd1;
      end
      calm = (ph_no != 2) && ($urandom_range(0, 4) == 0);
      tx_eager = (ph_no == 2);
      switch_phase(c);
      if (ph_no == 2) squeeze_req = 1'b1;
      len = $urandom_range(40, 140);
      repeat (len) begin
        style = $urandom_range(0, 99);
        s = $urandom();
        if (style < 55) begin
          // Measurement stays within -0x40000 to +0x3FFFF of the target.
          p = s + (32'($urandom_range(0, 32'h7FFFF)) - 32'h40000);
          v = s + (32'($urandom_range(0, 32'h7FFFF)) - 32'h40000);
        end else if (style < 80) begin
          p = $urandom();
          v = $urandom();
        end else begin
          p = edge_word();
          v = edge_word();
          s = edge_word();
        end
        k = ($urandom_range(0, 24) == 0);
        offer_tick(p, v, s, k);
        step_controller(p, v, s, k, fired, d);
        if (fired) drive_q.push_back(d);
        n_ticks++;
        pause_sender();
      end
      ph_no++;
    end

    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("[pid_position_velocity_controller] OK");
    end else begin
      $display("[pid_position_velocity_controller] ERROR");
    end
    $finish;
  end

endmodule
